// ===== sv/okvt_pkg.sv =====
`timescale 1ns / 1ps
// Package for the ordered key/value table: sizes, beat layouts, action and
// state codes, and the control word broadcast along the cell chain.
// No dependencies.
package okvt_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam int ACT_W = 3;
  localparam int KEY_W = 8;
  localparam int VAL_W = 32;
  localparam int OCC_W = 7;
  localparam int ECN_W = 7;
  localparam int CMP_W = (CNT_W > OCC_W) ? CNT_W : OCC_W;

  // input beat: action, key, value, occurrence
  localparam int ACT_LSB = 0;
  localparam int KEY_LSB = ACT_LSB + ACT_W;
  localparam int VAL_LSB = KEY_LSB + KEY_W;
  localparam int OCC_LSB = VAL_LSB + VAL_W;
  localparam int IN_RAW  = OCC_LSB + OCC_W;
  localparam int IN_W    = ((IN_RAW + 7) / 8) * 8;

  // output beat: found, result_value, entry_count, overflow
  localparam int OUT_RAW = 1 + VAL_W + ECN_W + 1;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;
  localparam int OUT_PAD = OUT_W - OUT_RAW;

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD      = 3'd0,
    ACT_GET      = 3'd1,
    ACT_SET      = 3'd2,
    ACT_POP      = 3'd3,
    ACT_REM_NTH  = 3'd4,
    ACT_REM_ALL  = 3'd5,
    ACT_REM_LAST = 3'd6
  } act_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPEND,
    ST_FIN
  } state_e;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_ROTATE,
    OP_DROP,
    OP_APPEND
  } cell_op_e;

  typedef struct packed {
    cell_op_e          op;
    logic [IDX_W-1:0]  tail;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
  } cell_ctl_t;

endpackage

// ===== sv/okvt_cell.sv =====
`timescale 1ns / 1ps
// One table slot of the ordered key/value table chain.
// Depends on okvt_pkg for widths and the broadcast control word.
module okvt_cell import okvt_pkg::*; (
  input  logic             clk_i,
  input  logic [IDX_W-1:0] idx_i,
  input  cell_ctl_t        ctl_i,
  input  logic [KEY_W-1:0] nbr_key_i,
  input  logic [VAL_W-1:0] nbr_val_i,
  output logic [KEY_W-1:0] key_o,
  output logic [VAL_W-1:0] val_o
);

  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic             below_tail, at_tail;

  always_comb begin
    below_tail = idx_i < ctl_i.tail;
    at_tail    = idx_i == ctl_i.tail;
    key_d      = key_q;
    val_d      = val_q;
    case (ctl_i.op)
      OP_ROTATE: begin
        if (below_tail) begin
          key_d = nbr_key_i;
          val_d = nbr_val_i;
        end else if (at_tail) begin
          key_d = ctl_i.key;
          val_d = ctl_i.val;
        end
      end
      OP_DROP: begin
        if (below_tail) begin
          key_d = nbr_key_i;
          val_d = nbr_val_i;
        end
      end
      OP_APPEND: begin
        if (at_tail) begin
          key_d = ctl_i.key;
          val_d = ctl_i.val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    val_q <= val_d;
  end

  assign key_o = key_q;
  assign val_o = val_q;

endmodule

// ===== sv/ordered_key_value_table.sv =====
`timescale 1ns / 1ps
// Ordered key/value table top level: request sequencer and the cell chain.
// Depends on okvt_pkg and okvt_cell.
//
// Usage: one request beat on the slave side (action, key, value, occurrence)
// gives exactly one response beat on the master side (found, result_value,
// entry_count, overflow). Live entries sit in cells 0..count-1; a request
// rotates the live part of the chain one place per cycle so each entry
// passes cell 0 once per lap, where it is compared, updated, read or dropped.
// Drops close the gap as the rotation goes, so table order is kept.
// Remove-last takes a counting lap and then a removing lap. One request is
// worked on at a time, and the slave side is ready again in the cycle the
// response appears.
// The response sits in an output register; a new request is taken while it
// waits, and a stalled receiver holds the block in its final state only
// once the next response is ready. Reset empties the table at once.
module ordered_key_value_table import okvt_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // action, key, value, occurrence (lowest bit up), zero padded
  input  logic [IN_W-1:0]  s_axis_tdata_i,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  // found, result_value, entry_count, overflow (lowest bit up), zero padded
  output logic [OUT_W-1:0] m_axis_tdata_o
);

  logic [KEY_W-1:0] cell_key [ENTRIES];
  logic [VAL_W-1:0] cell_val [ENTRIES];
  cell_ctl_t        ctl;

  state_e           state_q, state_d;
  act_e             act_q, act_d;
  logic [KEY_W-1:0] rkey_q, rkey_d;
  logic [VAL_W-1:0] rval_q, rval_d;
  logic [CMP_W-1:0] tgt_q, tgt_d;
  logic [CMP_W-1:0] seen_q, seen_d, seen_inc;
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W-1:0] count_q, count_d, tail_w;
  logic             found_q, found_d;
  logic             done_q, done_d;
  logic             ovf_q, ovf_d;
  logic             phase_q, phase_d;
  logic [VAL_W-1:0] res_q, res_d;
  logic             mvalid_q, mvalid_d;
  logic [OUT_W-1:0] mdata_q, mdata_d;

  logic             in_beat, key_eq, val_eq, drop, nth_hit;
  logic [CNT_W+ECN_W-1:0] cnt_ext;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KEY_W-1:0] nk;
    logic [VAL_W-1:0] nv;
    if (i == ENTRIES - 1) begin : g_last
      assign nk = ctl.key;
      assign nv = ctl.val;
    end else begin : g_mid
      assign nk = cell_key[i+1];
      assign nv = cell_val[i+1];
    end
    okvt_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (IDX_W'(i)),
      .ctl_i     (ctl),
      .nbr_key_i (nk),
      .nbr_val_i (nv),
      .key_o     (cell_key[i]),
      .val_o     (cell_val[i])
    );
  end

  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = state_q == ST_IDLE;
  assign key_eq          = cell_key[0] == rkey_q;
  assign val_eq          = cell_val[0] == rval_q;
  assign seen_inc        = seen_q + CMP_W'(1);
  assign nth_hit         = val_eq && !done_q && (seen_inc == tgt_q);
  assign tail_w          = count_q - CNT_W'(1);
  assign cnt_ext         = {{ECN_W{1'b0}}, count_q};

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    rkey_d   = rkey_q;
    rval_d   = rval_q;
    tgt_d    = tgt_q;
    seen_d   = seen_q;
    rem_d    = rem_q;
    count_d  = count_q;
    found_d  = found_q;
    done_d   = done_q;
    ovf_d    = ovf_q;
    phase_d  = phase_q;
    res_d    = res_q;
    mvalid_d = mvalid_q;
    mdata_d  = mdata_q;
    drop     = 1'b0;
    ctl.op   = OP_HOLD;
    ctl.tail = tail_w[IDX_W-1:0];
    ctl.key  = cell_key[0];
    ctl.val  = cell_val[0];

    if (mvalid_q && m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          act_d   = act_e'(s_axis_tdata_i[ACT_LSB +: ACT_W]);
          rkey_d  = s_axis_tdata_i[KEY_LSB +: KEY_W];
          rval_d  = s_axis_tdata_i[VAL_LSB +: VAL_W];
          tgt_d   = CMP_W'(s_axis_tdata_i[OCC_LSB +: OCC_W]);
          seen_d  = '0;
          found_d = 1'b0;
          done_d  = 1'b0;
          ovf_d   = 1'b0;
          phase_d = 1'b0;
          res_d   = '0;
          rem_d   = count_q;
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rem_q != '0) begin
          rem_d  = rem_q - CNT_W'(1);
          ctl.op = OP_ROTATE;
          case (act_q)
            ACT_ADD, ACT_SET: begin
              if (key_eq && !done_q) begin
                ctl.val = rval_q;
                found_d = 1'b1;
                done_d  = 1'b1;
              end
            end
            ACT_GET: begin
              if (key_eq && !done_q) begin
                res_d   = cell_val[0];
                found_d = 1'b1;
                done_d  = 1'b1;
              end
            end
            ACT_POP: begin
              if (key_eq && !done_q) begin
                res_d   = cell_val[0];
                found_d = 1'b1;
                done_d  = 1'b1;
                drop    = 1'b1;
              end
            end
            ACT_REM_NTH: begin
              if (val_eq && !done_q) seen_d = seen_inc;
              if (nth_hit) begin
                found_d = 1'b1;
                done_d  = 1'b1;
                drop    = 1'b1;
              end
            end
            ACT_REM_ALL: begin
              if (val_eq) begin
                found_d = 1'b1;
                drop    = 1'b1;
              end
            end
            ACT_REM_LAST: begin
              if (!phase_q) begin
                if (val_eq) seen_d = seen_inc;
              end else begin
                if (val_eq && !done_q) seen_d = seen_inc;
                if (nth_hit) begin
                  found_d = 1'b1;
                  done_d  = 1'b1;
                  drop    = 1'b1;
                end
              end
            end
            default: ;
          endcase
          if (drop) begin
            ctl.op  = OP_DROP;
            count_d = count_q - CNT_W'(1);
          end
        end else if (act_q == ACT_REM_LAST && !phase_q) begin
          phase_d = 1'b1;
          tgt_d   = seen_q;
          seen_d  = '0;
          rem_d   = count_q;
        end else if (act_q == ACT_ADD && !found_q) begin
          if (count_q == CNT_W'(ENTRIES)) begin
            ovf_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_APPEND;
          end
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_APPEND: begin
        ctl.op   = OP_APPEND;
        ctl.tail = count_q[IDX_W-1:0];
        ctl.key  = rkey_q;
        ctl.val  = rval_q;
        count_d  = count_q + CNT_W'(1);
        state_d  = ST_FIN;
      end
      ST_FIN: begin
        if (!mvalid_q || m_axis_tready_i) begin
          mvalid_d = 1'b1;
          mdata_d  = {{OUT_PAD{1'b0}}, ovf_q, cnt_ext[ECN_W-1:0], res_q, found_q};
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      count_q  <= '0;
      rem_q    <= '0;
      phase_q  <= 1'b0;
      done_q   <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      rem_q    <= rem_d;
      phase_q  <= phase_d;
      done_q   <= done_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    rkey_q  <= rkey_d;
    rval_q  <= rval_d;
    tgt_q   <= tgt_d;
    seen_q  <= seen_d;
    found_q <= found_d;
    ovf_q   <= ovf_d;
    res_q   <= res_d;
    mdata_q <= mdata_d;
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = mdata_q;

endmodule

// ===== sv/okvt_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the ordered key/value table, bound to the top level.
// Depends on okvt_pkg and ordered_key_value_table.
module okvt_checker import okvt_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid_i,
  input logic             s_axis_tready_o,
  input logic             m_axis_tvalid_o,
  input logic             m_axis_tready_i,
  input logic [OUT_W-1:0] m_axis_tdata_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("response beat changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while another is in work");

  a_no_instant_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !$rose(m_axis_tvalid_o))
    else $error("response appeared a cycle after the request");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[VAL_W+ECN_W+1] |->
      !m_axis_tdata_o[0] && (m_axis_tdata_o[VAL_W+1 +: ECN_W] == ECN_W'(ENTRIES)))
    else $error("overflow without a full table");

  a_val_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1 +: VAL_W] != '0) |-> m_axis_tdata_o[0])
    else $error("result value on a miss");

endmodule

bind ordered_key_value_table okvt_checker u_okvt_checker (.*);
